// ===== src/dsq_pkg.sv =====
// Shared constants, codes and types of the seek-sorted disk request queue.
package dsq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int CYLINDER_WIDTH = 16;
    localparam int TAG_WIDTH      = 8;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    typedef struct packed {
        logic [CYLINDER_WIDTH-1:0] cyl;
        logic                      rd;
        logic [TAG_WIDTH-1:0]      tag;
    } t_entry;

    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic                      best_ok;
        logic [CYLINDER_WIDTH-1:0] best_cyl;
        logic [IDX_W-1:0]          best_idx;
    } t_token;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] count;
        t_entry           item;
    } t_ctl;

endpackage

// ===== src/dsq_cell.sv =====
// One queue slot: holds a request, shifts with its neighbours and passes the search token on.
module dsq_cell
    import dsq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_ctl             i_ctl,
    input  t_entry           i_left,
    input  t_entry           i_right,
    input  t_token           i_tok,
    output t_entry           o_entry,
    output t_token           o_tok
);

    t_entry r_entry;
    t_entry n_entry;
    t_token r_tok;
    t_token n_tok;
    logic   w_in_range;
    logic   w_after_pos;
    logic   w_at_pos;

    assign w_in_range  = {1'b0, i_index} < i_ctl.count;
    assign w_after_pos = {1'b0, i_index} > i_ctl.pos;
    assign w_at_pos    = {1'b0, i_index} == i_ctl.pos;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.done && w_in_range) begin
            if (i_ctl.item.rd && !r_entry.rd) begin
                if (!i_tok.best_ok) begin
                    n_tok.best_ok  = 1'b1;
                    n_tok.best_idx = i_index;
                end
                n_tok.done = 1'b1;
            end else if (!i_ctl.item.rd && r_entry.rd) begin
                n_tok = i_tok;
            end else if (r_entry.cyl <= i_ctl.item.cyl &&
                         (!i_tok.best_ok || r_entry.cyl >= i_tok.best_cyl)) begin
                n_tok.best_ok  = 1'b1;
                n_tok.best_cyl = r_entry.cyl;
                n_tok.best_idx = i_index;
            end
        end
    end

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (w_after_pos) begin
                    n_entry = i_left;
                end else if (w_at_pos) begin
                    n_entry = i_ctl.item;
                end
            end
            OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

// ===== src/disk_request_seek_sort_queue.sv =====
// Top level of the seek-sorted disk request queue: control, chain of cells and result register.
//
//   channel | valid   | stall   | payload
//   input   | i_valid | o_stall | i_mode, i_cylinder, i_is_read, i_tag
//   output  | o_valid | i_stall | o_status, o_head_tag, o_head_cylinder, o_head_is_read,
//           |         |         | o_occupancy
//
// A pop, or an insert into a full queue, is answered from the idle state without a scan.
// An accepted insert occupies the block while the search token walks the chain one cell per cycle
// through the token register of every cell; every cell then shifts or loads in the same cycle
// as the result is registered, and the following item is taken once the block is idle again.
// Reset clears the entry count, the control state and the result valid flag.
// While a result is held by a stall, no new item is taken.
module disk_request_seek_sort_queue
    import dsq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_mode,
    input  logic [CYLINDER_WIDTH-1:0] i_cylinder,
    input  logic                      i_is_read,
    input  logic [TAG_WIDTH-1:0]      i_tag,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [TAG_WIDTH-1:0]      o_head_tag,
    output logic [CYLINDER_WIDTH-1:0] o_head_cylinder,
    output logic                      o_head_is_read,
    output logic [CNT_W-1:0]          o_occupancy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    t_entry                    r_new;
    logic                      r_start;
    logic                      n_start;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [STATUS_W-1:0]       n_status;
    t_entry                    r_head;
    t_entry                    n_head;
    logic [CNT_W-1:0]          r_occ;
    logic [CNT_W-1:0]          n_occ;

    logic   w_out_free;
    logic   w_accept;
    t_ctl   w_ctl;
    t_entry w_entry [QUEUE_DEPTH];
    t_token w_tok   [QUEUE_DEPTH+1];

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    assign w_tok[0] = {r_start, {($bits(t_token) - 1){1'b0}}};

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_entry[k-1];
            end
            if (k == QUEUE_DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner_r
                assign w_right = w_entry[k+1];
            end
            dsq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(k)),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_tok   (w_tok[k]),
                .o_entry (w_entry[k]),
                .o_tok   (w_tok[k+1])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start     = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_head      = r_head;
        n_occ       = r_occ;
        w_ctl.op    = OP_NONE;
        w_ctl.pos   = r_count;
        w_ctl.count = r_count;
        w_ctl.item  = r_new;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_head      = '0;
                    n_occ       = r_count;
                    if (i_mode == MODE_POP) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_ctl.op = OP_POP;
                            n_head   = w_entry[0];
                            n_count  = r_count - CNT_W'(1);
                            n_occ    = n_count;
                        end
                    end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_out_valid = r_out_valid && i_stall;
                        n_start     = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_tok[QUEUE_DEPTH].valid && w_out_free) begin
                    w_ctl.op = OP_INSERT;
                    if (w_tok[QUEUE_DEPTH].best_ok) begin
                        w_ctl.pos = CNT_W'(w_tok[QUEUE_DEPTH].best_idx) + CNT_W'(1);
                    end
                    n_count     = r_count + CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_head      = '0;
                    n_occ       = n_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new.cyl <= i_cylinder;
            r_new.rd  <= i_is_read;
            r_new.tag <= i_tag;
        end
        r_status <= n_status;
        r_head   <= n_head;
        r_occ    <= n_occ;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_head_tag      = r_head.tag;
    assign o_head_cylinder = r_head.cyl;
    assign o_head_is_read  = r_head.rd;
    assign o_occupancy     = r_occ;

endmodule
